### src/hcbp_pkg.sv
package hcbp_pkg;

    // Block sizing
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int CNT_W        = 3;
    localparam int WIN_W        = CODE_W + BYTE_W;

    // Item function codes
    localparam logic [1:0] FN_LOAD   = 2'd0;
    localparam logic [1:0] FN_ENCODE = 2'd1;
    localparam logic [1:0] FN_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out;

    // Microcode program counter and step addresses
    typedef logic [2:0] t_upc;
    localparam t_upc U_FETCH  = 3'd0;
    localparam t_upc U_LOAD   = 3'd1;
    localparam t_upc U_BUILD  = 3'd2;
    localparam t_upc U_EMIT   = 3'd3;
    localparam t_upc U_KEEP   = 3'd4;
    localparam t_upc U_FLUSH  = 3'd5;
    localparam t_upc U_FLEMIT = 3'd6;

    // Datapath actions
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_BUILD,
        ACT_EMIT,
        ACT_KEEP,
        ACT_FLUSH
    } t_act;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_DISPATCH,
        JC_SHORT,
        JC_MORE,
        JC_EMPTY
    } t_jc;

    typedef struct packed {
        logic in_rdy;
        logic need_out;
        t_act act;
        t_jc  jc;
        t_upc target;
    } t_uword;

    // Control store: one word per step
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            U_FETCH:  w = '{in_rdy: 1'b1, need_out: 1'b0, act: ACT_NONE,
                            jc: JC_DISPATCH, target: U_FETCH};
            U_LOAD:   w = '{in_rdy: 1'b0, need_out: 1'b0, act: ACT_WRITE,
                            jc: JC_ALWAYS, target: U_FETCH};
            U_BUILD:  w = '{in_rdy: 1'b0, need_out: 1'b0, act: ACT_BUILD,
                            jc: JC_SHORT, target: U_KEEP};
            U_EMIT:   w = '{in_rdy: 1'b0, need_out: 1'b1, act: ACT_EMIT,
                            jc: JC_MORE, target: U_EMIT};
            U_KEEP:   w = '{in_rdy: 1'b0, need_out: 1'b0, act: ACT_KEEP,
                            jc: JC_ALWAYS, target: U_FETCH};
            U_FLUSH:  w = '{in_rdy: 1'b0, need_out: 1'b0, act: ACT_NONE,
                            jc: JC_EMPTY, target: U_FETCH};
            U_FLEMIT: w = '{in_rdy: 1'b0, need_out: 1'b1, act: ACT_FLUSH,
                            jc: JC_ALWAYS, target: U_FETCH};
            default:  w = '{in_rdy: 1'b0, need_out: 1'b0, act: ACT_NONE,
                            jc: JC_ALWAYS, target: U_FETCH};
        endcase
        return w;
    endfunction

    // Entry step for each item function
    function automatic t_upc dispatch(input logic [1:0] func);
        t_upc pc;
        case (func)
            FN_LOAD:   pc = U_LOAD;
            FN_ENCODE: pc = U_BUILD;
            FN_FLUSH:  pc = U_FLUSH;
            default:   pc = U_FETCH;
        endcase
        return pc;
    endfunction

endpackage

### src/huffman_code_bit_packer_unit.sv
// Prefix-code bit packer. A load beat writes one entry of the code table, an encode beat
// appends the code of its byte to the pending bits and sends each completed byte as one
// output beat (earliest bit in the MSB, last set on the final byte of that item), and a
// flush beat sends the pending bits padded with zeros. One item is worked at a time by a
// small microcoded sequencer: load fetches and writes; flush fetches, checks and emits if
// bits pend; encode fetches, builds, emits each byte and keeps; each emit waits while the
// output register is still full. Table lengths read as zero after reset through per-entry
// valid bits, so the block is ready at once; table memories have a registered read port.
module huffman_code_bit_packer_unit
    import hcbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_upc                 r_pc, n_pc;
    t_uword               w;
    t_in                  r_item;
    logic                 r_sym_ok;
    logic [LEN_W-1:0]     len_mem [SYMBOL_COUNT];
    logic [CODE_W-1:0]    pat_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]     r_len_rd;
    logic [CODE_W-1:0]    r_pat_rd;
    logic [SYMBOL_COUNT-1:0] r_vld;
    logic [BYTE_W-1:0]    r_pend;
    logic [CNT_W-1:0]     r_cnt;
    logic [WIN_W-1:0]     r_win;
    logic [LEN_W-1:0]     r_tot;
    t_out                 r_out;
    logic                 r_ovld;

    logic                 in_acc;
    logic                 slot_free;
    logic                 hold;
    logic                 out_load;
    logic [SYM_IDX_W-1:0] in_idx;
    logic [SYM_IDX_W-1:0] item_idx;
    logic                 in_sym_ok;
    logic [LEN_W-1:0]     load_len;
    logic [LEN_W-1:0]     eff_len;
    logic [CODE_W-1:0]    pat_left;
    logic [WIN_W-1:0]     build_win;
    logic [LEN_W-1:0]     build_tot;

    assign in_idx    = i_data.symbol[SYM_IDX_W-1:0];
    assign item_idx  = r_item.symbol[SYM_IDX_W-1:0];
    assign in_sym_ok = ({1'b0, i_data.symbol} < 9'(SYMBOL_COUNT));
    assign in_acc    = i_valid && o_ready;
    assign slot_free = !r_ovld || i_ready;

    // Decode the current control word
    always_comb begin
        w       = ucode(r_pc);
        hold    = w.need_out && !slot_free;
        o_ready = w.in_rdy;
    end

    // Load the output register on a byte step that is not held
    assign out_load = w.need_out && !hold;

    // Next step: conditional jump or fall through, hold while output is full
    always_comb begin
        case (w.jc)
            JC_ALWAYS:   n_pc = w.target;
            JC_DISPATCH: n_pc = in_acc ? dispatch(i_data.func) : r_pc;
            JC_SHORT:    n_pc = (build_tot < LEN_W'(BYTE_W)) ? w.target : r_pc + 3'd1;
            JC_MORE:     n_pc = (r_tot >= LEN_W'(2 * BYTE_W)) ? w.target : r_pc + 3'd1;
            JC_EMPTY:    n_pc = (r_cnt == '0) ? w.target : r_pc + 3'd1;
            default:     n_pc = U_FETCH;
        endcase
        if (hold) begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Capture the item and start the table read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item   <= i_data;
            r_sym_ok <= in_sym_ok;
            r_len_rd <= len_mem[in_idx];
            r_pat_rd <= pat_mem[in_idx];
        end
    end

    // Saturate the loaded length
    assign load_len = (r_item.code_length > LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : r_item.code_length;

    // Write the code table
    always_ff @(posedge i_clk) begin
        if (w.act == ACT_WRITE && r_sym_ok) begin
            len_mem[item_idx] <= load_len;
            pat_mem[item_idx] <= r_item.code_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w.act == ACT_WRITE && r_sym_ok) begin
            r_vld[item_idx] <= 1'b1;
        end
    end

    // Align pending bits and code into one window, MSB first
    assign eff_len   = (r_vld[item_idx] && r_sym_ok) ? r_len_rd : '0;
    assign pat_left  = r_pat_rd << (LEN_W'(CODE_W) - eff_len);
    assign build_win = {r_pend, {CODE_W{1'b0}}} | ({pat_left, {BYTE_W{1'b0}}} >> r_cnt);
    assign build_tot = LEN_W'(r_cnt) + eff_len;

    // Window, pending bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            if (!hold) begin
                case (w.act)
                    ACT_BUILD: begin
                        r_win <= build_win;
                        r_tot <= build_tot;
                    end
                    ACT_EMIT: begin
                        r_out.out_byte <= r_win[WIN_W-1 -: BYTE_W];
                        r_out.last     <= (r_tot < LEN_W'(2 * BYTE_W));
                        r_win          <= r_win << BYTE_W;
                        r_tot          <= r_tot - LEN_W'(BYTE_W);
                    end
                    ACT_KEEP: begin
                        r_pend <= r_win[WIN_W-1 -: BYTE_W];
                        r_cnt  <= r_tot[CNT_W-1:0];
                    end
                    ACT_FLUSH: begin
                        r_out.out_byte <= r_pend;
                        r_out.last     <= 1'b1;
                        r_pend         <= '0;
                        r_cnt          <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

endmodule

### src/hcbp_checker.sv
module hcbp_checker
    import hcbp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input t_in  i_in_data,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output beat changed");

    // Drop ready after taking a real item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_data.func == FN_LOAD || i_in_data.func == FN_ENCODE ||
         i_in_data.func == FN_FLUSH) |=> !i_in_ready)
        else $error("input ready stayed high while an item is in work");

    // New output beats come only from busy steps
    a_emit_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("output beat raised while waiting for input");

    // A load never starts an output beat
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_data.func == FN_LOAD |=> !$rose(i_out_valid))
        else $error("load item produced an output beat");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_ready  (o_ready),
    .i_in_data   (i_data),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);
